FILE: design/cia_pkg.sv
// Shared types, register codes and a saturation helper for the impulse accumulator.
package cia_pkg;

  localparam logic [1:0] REG_RESTITUTION = 2'd0;
  localparam logic [1:0] REG_IMPULSE_CAP = 2'd1;
  localparam logic [1:0] REG_APPLY_THRESHOLD = 2'd2;

  localparam logic [14:0] RESTITUTION_RESET = 15'd13107;
  localparam logic [30:0] IMPULSE_CAP_RESET = 31'd1638400000;
  localparam logic [31:0] APPLY_THRESHOLD_RESET = 32'd268;

  // Q.28 dot product times (1+e) in Q2.14, shifted down by 14, stays below 2^49
  localparam int DVD_W = 49;
  localparam int DVS_W = 23;
  localparam int CNT_W = $clog2(DVD_W + 1);

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               en;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } store_wr_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

FILE: design/cia_store.sv
// Per-body impulse sum memory with registered read and reset valid bits.
module cia_store #(
  parameter int DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr,
  output logic signed [31:0]          rd_x,
  output logic signed [31:0]          rd_y,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  cia_pkg::store_wr_t          wr
);

  logic [63:0]      mem [DEPTH];
  logic [DEPTH-1:0] live;
  logic [63:0]      rd_data;
  logic             rd_live;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= {wr.y, wr.x};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      rd_live <= 1'b0;
    end else begin
      if (wr.en) begin
        live[wr_addr] <= 1'b1;
      end
      rd_live <= live[rd_addr];
    end
  end

  // entries never written since reset read as zero
  assign rd_x = rd_live ? rd_data[31:0] : 32'sd0;
  assign rd_y = rd_live ? rd_data[63:32] : 32'sd0;

endmodule

FILE: design/cia_div.sv
// Restoring divider, one quotient bit per cycle.
module cia_div (
  input  logic                        clk,
  input  logic                        rst,
  input  cia_pkg::div_req_t           req,
  output logic                        done,
  output logic [cia_pkg::DVD_W-1:0]   quotient
);

  logic                         busy;
  logic [cia_pkg::CNT_W-1:0]    count;
  logic [cia_pkg::DVD_W-1:0]    dvd;
  logic [cia_pkg::DVS_W-1:0]    dvs;
  logic [cia_pkg::DVS_W-1:0]    rem;
  logic [cia_pkg::DVS_W:0]      trial;
  logic                         fits;

  assign trial = {rem, dvd[cia_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= cia_pkg::CNT_W'(cia_pkg::DVD_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == cia_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd      <= req.dividend;
      dvs      <= req.divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[cia_pkg::DVD_W-2:0], 1'b0};
      rem      <= fits ? cia_pkg::DVS_W'(trial - {1'b0, dvs}) : trial[cia_pkg::DVS_W-1:0];
      quotient <= {quotient[cia_pkg::DVD_W-2:0], fits};
    end
  end

endmodule

FILE: design/contact_impulse_accumulator.sv
// Top level: contact impulse accumulator sequencer and fixed-point datapath.
//
//  channel  dir  handshake           payload
//  s_axis   in   s_tvalid/s_tready   s_tdata (contact fields), s_tuser (mode)
//  m_axis   out  m_tvalid/m_tready   m_tdata (sums, velocities), m_tuser (applied)
//  cfg      in   cfg_wen             cfg_index, cfg_data
//
// One request at a time. Collide runs through read, three product stages, divider
// start, a 49-bit bit-serial divide and three scale stages; apply through read and
// the apply stages; a collide with zero total inverse mass or an out-of-range body
// from read to the result. The next request is taken as the result appears. Reset
// clears the sum store at once through per-entry valid bits. A stalled result
// holds in the output register and the sequencer waits for it.
module contact_impulse_accumulator #(
  parameter int NUM_BODIES = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // body_index, inv_mass_self, inv_mass_other, vel_self_x, vel_self_y,
  // vel_other_x, vel_other_y, normal_x, normal_y, 4 zero bits
  input  logic [215:0] s_tdata,
  // mode
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // sum_x, sum_y, new_vel_x, new_vel_y
  output logic [127:0] m_tdata,
  // applied
  output logic [0:0]   m_tuser,
  input  logic         cfg_wen,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int DEPTH = (NUM_BODIES < 256) ? NUM_BODIES : 256;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_C1   = 4'd2;
  localparam logic [3:0] S_C2   = 4'd3;
  localparam logic [3:0] S_C3   = 4'd4;
  localparam logic [3:0] S_DIVS = 4'd5;
  localparam logic [3:0] S_DIVW = 4'd6;
  localparam logic [3:0] S_M1   = 4'd7;
  localparam logic [3:0] S_M2   = 4'd8;
  localparam logic [3:0] S_M3   = 4'd9;
  localparam logic [3:0] S_AP1  = 4'd10;
  localparam logic [3:0] S_AP2  = 4'd11;
  localparam logic [3:0] S_RES  = 4'd12;

  logic [3:0]  state, state_next;
  logic [14:0] restitution;
  logic [30:0] impulse_cap;
  logic [31:0] apply_threshold;

  logic               mode;
  logic               idx_ok;
  logic [AW-1:0]      addr;
  logic [21:0]        ma;
  logic [22:0]        den;
  logic signed [31:0] vsx, vsy, vox, voy;
  logic signed [15:0] nx, ny;
  logic signed [31:0] sx, sy, rx, ry;
  logic signed [47:0] dxp, dyp;
  logic signed [48:0] dsum;
  logic               pneg;
  logic [cia_pkg::DVD_W-1:0] dvd;
  logic signed [31:0] jimp;
  logic signed [47:0] tx, ty;
  logic signed [54:0] ux, uy;
  logic [63:0]        sqx, sqy;

  logic signed [31:0] rd_x, rd_y;
  cia_pkg::store_wr_t wr;
  cia_pkg::div_req_t  dreq;
  logic               div_done;
  logic [cia_pkg::DVD_W-1:0] quot;

  logic               accept;
  logic               out_free;
  logic [7:0]         in_idx;

  logic signed [65:0] prod_p;
  logic [65:0]        pmag;
  logic [30:0]        jmag;
  logic signed [31:0] tsx, tsy, usx, usy, nsx, nsy;
  logic [31:0]        ax, ay;
  logic [64:0]        len2;
  logic               do_apply;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign in_idx   = s_tdata[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution     <= cia_pkg::RESTITUTION_RESET;
      impulse_cap     <= cia_pkg::IMPULSE_CAP_RESET;
      apply_threshold <= cia_pkg::APPLY_THRESHOLD_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        cia_pkg::REG_RESTITUTION:     restitution     <= cfg_data[14:0];
        cia_pkg::REG_IMPULSE_CAP:     impulse_cap     <= cfg_data[30:0];
        cia_pkg::REG_APPLY_THRESHOLD: apply_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  cia_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (in_idx[AW-1:0]),
    .rd_x    (rd_x),
    .rd_y    (rd_y),
    .wr_addr (addr),
    .wr      (wr)
  );

  cia_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .done     (div_done),
    .quotient (quot)
  );

  assign dreq.start    = (state == S_DIVS);
  assign dreq.dividend = dvd;
  assign dreq.divisor  = den;

  // combinational pieces for each stage
  assign prod_p = 66'(dsum) * 66'(signed'({1'b0, 16'(17'd16384 + 17'(restitution))}));
  assign pmag   = prod_p[65] ? 66'(-prod_p) : 66'(prod_p);
  assign jmag   = (quot > cia_pkg::DVD_W'(impulse_cap)) ? impulse_cap : quot[30:0];
  assign tsx    = cia_pkg::sat32(64'(tx >>> 14));
  assign tsy    = cia_pkg::sat32(64'(ty >>> 14));
  assign usx    = cia_pkg::sat32(64'(ux >>> 14));
  assign usy    = cia_pkg::sat32(64'(uy >>> 14));
  assign nsx    = cia_pkg::sat32(64'(sx) + 64'(usx));
  assign nsy    = cia_pkg::sat32(64'(sy) + 64'(usy));
  assign ax     = sx[31] ? 32'(-sx) : 32'(sx);
  assign ay     = sy[31] ? 32'(-sy) : 32'(sy);
  assign len2   = 65'(sqx) + 65'(sqy);
  assign do_apply = len2 > 65'(apply_threshold);

  always_comb begin
    wr.en = 1'b0;
    wr.x  = nsx;
    wr.y  = nsy;
    if (state == S_M3 && out_free) begin
      wr.en = 1'b1;
    end else if (state == S_AP2 && out_free && do_apply) begin
      wr.en = 1'b1;
      wr.x  = 32'sd0;
      wr.y  = 32'sd0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_RD;
      S_RD: begin
        if (mode) begin
          state_next = S_AP1;
        end else if (!idx_ok || den == '0) begin
          state_next = S_RES;
        end else begin
          state_next = S_C1;
        end
      end
      S_C1:   state_next = S_C2;
      S_C2:   state_next = S_C3;
      S_C3:   state_next = S_DIVS;
      S_DIVS: state_next = S_DIVW;
      S_DIVW: if (div_done) state_next = S_M1;
      S_M1:   state_next = S_M2;
      S_M2:   state_next = S_M3;
      S_M3:   if (out_free) state_next = S_IDLE;
      S_AP1:  state_next = S_AP2;
      S_AP2:  if (out_free) state_next = S_IDLE;
      S_RES:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_M3 || state == S_AP2 || state == S_RES) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode   <= s_tuser[0];
      idx_ok <= 32'(in_idx) < NUM_BODIES;
      addr   <= in_idx[AW-1:0];
      ma     <= s_tdata[29:8];
      den    <= 23'(s_tdata[29:8]) + 23'(s_tdata[51:30]);
      vsx    <= s_tdata[83:52];
      vsy    <= s_tdata[115:84];
      vox    <= s_tdata[147:116];
      voy    <= s_tdata[179:148];
      nx     <= s_tdata[195:180];
      ny     <= s_tdata[211:196];
    end
    case (state)
      S_RD: begin
        // drop the sum of a body outside the table
        sx <= idx_ok ? rd_x : 32'sd0;
        sy <= idx_ok ? rd_y : 32'sd0;
        rx <= cia_pkg::sat32(64'(vsx) - 64'(vox));
        ry <= cia_pkg::sat32(64'(vsy) - 64'(voy));
      end
      S_C1: begin
        dxp <= 48'(rx) * 48'(nx);
        dyp <= 48'(ry) * 48'(ny);
      end
      S_C2: dsum <= 49'(dxp) + 49'(dyp);
      S_C3: begin
        // the impulse is negated, so a positive product gives a negative impulse
        pneg <= !prod_p[65] && (prod_p != '0);
        dvd  <= pmag[62:14];
      end
      S_DIVW: if (div_done) jimp <= pneg ? 32'(-33'(jmag)) : 32'(jmag);
      S_M1: begin
        tx <= 48'(nx) * 48'(jimp);
        ty <= 48'(ny) * 48'(jimp);
      end
      S_M2: begin
        ux <= 55'(tsx) * 55'(signed'({1'b0, ma}));
        uy <= 55'(tsy) * 55'(signed'({1'b0, ma}));
      end
      S_AP1: begin
        sqx <= 64'(ax) * 64'(ax);
        sqy <= 64'(ay) * 64'(ay);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      case (state)
        S_M3: begin
          m_tdata <= {vsy, vsx, nsy, nsx};
          m_tuser <= 1'b0;
        end
        S_AP2: begin
          if (do_apply) begin
            m_tdata <= {cia_pkg::sat32(64'(vsy) + 64'(sy)),
                        cia_pkg::sat32(64'(vsx) + 64'(sx)), 64'd0};
            m_tuser <= 1'b1;
          end else begin
            m_tdata <= {vsy, vsx, sy, sx};
            m_tuser <= 1'b0;
          end
        end
        S_RES: begin
          m_tdata <= {vsy, vsx, sy, sx};
          m_tuser <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule
